// File: hw/rtl/pcm_pkg.sv
// pcm_pkg: shared types, codes and constants for the path count matrix unit.
// No dependencies; imported by every module of the block.
package pcm_pkg;

    // Build-time defaults and fixed field widths
    localparam int PCM_MAX_NODES = 32;
    localparam int PCM_IDX_W     = 6;    // row / column index, covers up to 64 nodes
    localparam int PCM_CNT_W     = 7;    // node count, 0 to 64
    localparam logic [31:0] INF_CODE = 32'hFFFF_FFFF;
    localparam logic [31:0] SAT_MAX  = 32'h7FFF_FFFF;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    // Operation applied by every cell during one pass over the rows
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_COPY,
        OP_CLOS,
        OP_INF,
        OP_INIT,
        OP_ACC
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LATCH,
        S_STREAM,
        S_DRAIN,
        S_READ
    } t_state;

    // Token travelling down the chain: one row and the pivot column value
    typedef struct packed {
        logic                 vld;
        logic [PCM_IDX_W-1:0] row;
        logic                 a_r;
        logic [31:0]          a_c;
    } t_tok;

    // Data read from a cell on the broadcast port
    typedef struct packed {
        logic        r;
        logic [31:0] c;
    } t_bdat;

    // Control shared by all cells
    typedef struct packed {
        t_op                  op;
        logic [PCM_CNT_W-1:0] n;
        logic                 kk;
        logic                 bload;
        logic [PCM_IDX_W-1:0] addr_b;
        logic                 edge_we;
        logic [PCM_IDX_W-1:0] edge_row;
        logic [PCM_IDX_W-1:0] edge_col;
    } t_cell_ctl;

endpackage

// File: hw/rtl/pcm_cell.sv
// pcm_cell: one column of the edge, reach and count matrices with its update datapath.
// Depends on pcm_pkg.
module pcm_cell #(
    parameter int MAX_NODES = pcm_pkg::PCM_MAX_NODES,
    parameter int J         = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcm_pkg::t_cell_ctl i_ctl,
    input  pcm_pkg::t_tok     i_tok,
    output pcm_pkg::t_tok     o_tok,
    output pcm_pkg::t_bdat    o_bdat
);
    import pcm_pkg::*;

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic        m_edge  [MAX_NODES];
    logic        m_reach [MAX_NODES];
    logic [31:0] m_cnt   [MAX_NODES];

    t_tok        r_tok, r1_tok, r2_tok;
    logic        r1_e, r2_e;
    logic [31:0] r1_c, r2_c;
    logic [63:0] r2_prod;
    logic        r_br;
    logic [31:0] r_bc;
    t_bdat       r_bd;

    logic        in_range;
    logic        skip;
    logic [63:0] prod;
    logic [64:0] sum;
    logic [31:0] acc_val;
    logic [NW-1:0] wr_row;

    assign o_tok  = r_tok;
    assign o_bdat = r_bd;

    // Token pipeline: chain register, read stage, multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld  <= 1'b0;
            r1_tok.vld <= 1'b0;
            r2_tok.vld <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r1_tok <= r_tok;
            r2_tok <= r1_tok;
        end
    end

    // Pivot row values, latched once per pass
    always_ff @(posedge i_clk) begin
        if (i_ctl.bload) begin
            r_br <= r_bd.r;
            r_bc <= r_bd.c;
        end
    end

    assign prod = r1_tok.a_c * r_bc;

    always_ff @(posedge i_clk) begin
        r2_prod <= prod;
        r2_e    <= r1_e;
        r2_c    <= r1_c;
    end

    // Update of the written row
    always_comb begin
        in_range = (PCM_CNT_W'(J) < i_ctl.n);
        skip     = (r2_c == INF_CODE) || (r2_tok.a_c == INF_CODE) || (r_bc == INF_CODE);
        sum      = {1'b0, r2_prod} + {33'b0, r2_c};
        acc_val  = (sum > {33'b0, SAT_MAX}) ? SAT_MAX : sum[31:0];
        wr_row   = r2_tok.row[NW-1:0];
    end

    // Column storage: row read, broadcast read, row write and edge write
    always_ff @(posedge i_clk) begin
        r1_e    <= m_edge[r_tok.row[NW-1:0]];
        r1_c    <= m_cnt[r_tok.row[NW-1:0]];
        r_bd.r  <= m_reach[i_ctl.addr_b[NW-1:0]];
        r_bd.c  <= m_cnt[i_ctl.addr_b[NW-1:0]];
        if (r2_tok.vld) begin
            case (i_ctl.op)
                OP_CLEAR: begin
                    m_edge[wr_row] <= 1'b0;
                    m_cnt[wr_row]  <= '0;
                end
                OP_COPY: begin
                    m_reach[wr_row] <= r2_e;
                    m_cnt[wr_row]   <= '0;
                end
                OP_CLOS: begin
                    if (in_range && r2_tok.a_r && r_br) m_reach[wr_row] <= 1'b1;
                end
                OP_INF: begin
                    if (in_range && i_ctl.kk && r2_tok.a_r && r_br) m_cnt[wr_row] <= INF_CODE;
                end
                OP_INIT: begin
                    if (in_range && r2_c != INF_CODE && r2_e) m_cnt[wr_row] <= 32'd1;
                end
                OP_ACC: begin
                    if (in_range && !skip) m_cnt[wr_row] <= acc_val;
                end
                default: ;
            endcase
        end
        if (i_ctl.edge_we && i_ctl.edge_col == PCM_IDX_W'(J))
            m_edge[i_ctl.edge_row[NW-1:0]] <= 1'b1;
    end

endmodule

// File: hw/rtl/pcm_ctrl.sv
// pcm_ctrl: command decode, pass sequencer, node count and row read-out registers.
// Depends on pcm_pkg.
module pcm_ctrl #(
    parameter int MAX_NODES = pcm_pkg::PCM_MAX_NODES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic [1:0]                      i_command,
    input  logic [4:0]                      i_src_node,
    input  logic [4:0]                      i_dst_node,
    input  pcm_pkg::t_bdat                  i_sel_dat,
    output logic                            busy,
    output pcm_pkg::t_cell_ctl              o_ctl,
    output logic                            o_inj_vld,
    output logic [pcm_pkg::PCM_IDX_W-1:0]   o_inj_row,
    output logic [pcm_pkg::PCM_IDX_W-1:0]   o_msel,
    output logic                            o_valid,
    output logic [4:0]                      o_column,
    output logic                            o_last_entry
);
    import pcm_pkg::*;

    localparam logic [PCM_CNT_W-1:0] MAXN      = PCM_CNT_W'(MAX_NODES);
    localparam logic [PCM_CNT_W-1:0] DRAIN_LEN = PCM_CNT_W'(MAX_NODES + 4);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [PCM_IDX_W-1:0] r_k, n_k, r_rrow, n_rrow, r_col, n_col, r_msel, bsel;
    logic [PCM_CNT_W-1:0] r_row, n_row, r_cnt, n_cnt, r_nc, n_nc, rows;
    logic r_kk, r_inj_v, r_ov, r_olast;
    logic [PCM_IDX_W-1:0] r_inj_row;
    logic [4:0] r_ocol;
    logic accept, edge_ok, last_pass, last_k;
    logic [PCM_CNT_W-1:0] src_p1, dst_p1;
    t_cmd cmd;

    assign cmd     = t_cmd'(i_command);
    assign accept  = start && (r_state == S_IDLE);
    assign edge_ok = (PCM_CNT_W'(i_src_node) < MAXN) && (PCM_CNT_W'(i_dst_node) < MAXN);
    assign src_p1  = PCM_CNT_W'(i_src_node) + PCM_CNT_W'(1);
    assign dst_p1  = PCM_CNT_W'(i_dst_node) + PCM_CNT_W'(1);
    assign rows    = (r_op == OP_CLEAR || r_op == OP_COPY) ? MAXN : r_nc;
    assign last_k  = (PCM_CNT_W'(r_k) == r_nc - PCM_CNT_W'(1));
    assign last_pass = (r_op == OP_CLEAR) || (r_op == OP_ACC && last_k);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_CLEAR, CMD_COMPUTE: n_state = S_LOAD;
                        CMD_ADD:                n_state = S_IDLE;
                        CMD_READ: n_state = (PCM_CNT_W'(i_src_node) < r_nc) ? S_READ : S_IDLE;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD:   n_state = S_LATCH;
            S_LATCH:  n_state = S_STREAM;
            S_STREAM: if (r_row == rows - PCM_CNT_W'(1)) n_state = S_DRAIN;
            S_DRAIN: begin
                if (r_cnt == DRAIN_LEN - PCM_CNT_W'(1))
                    n_state = last_pass ? S_IDLE : S_LOAD;
            end
            S_READ: if (PCM_CNT_W'(r_col) == r_nc - PCM_CNT_W'(1)) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Pass, counter and node count updates
    always_comb begin
        n_op   = r_op;
        n_k    = r_k;
        n_row  = r_row;
        n_cnt  = r_cnt;
        n_nc   = r_nc;
        n_rrow = r_rrow;
        n_col  = r_col;
        case (r_state)
            S_IDLE: begin
                n_row = '0;
                n_cnt = '0;
                n_col = '0;
                n_k   = '0;
                if (accept) begin
                    case (cmd)
                        CMD_CLEAR: begin
                            n_op = OP_CLEAR;
                            n_nc = PCM_CNT_W'(1);
                        end
                        CMD_COMPUTE: n_op = OP_COPY;
                        CMD_ADD: begin
                            if (edge_ok) begin
                                if (src_p1 > n_nc) n_nc = src_p1;
                                if (dst_p1 > n_nc) n_nc = dst_p1;
                            end
                        end
                        default: n_rrow = PCM_IDX_W'(i_src_node);
                    endcase
                end
            end
            S_STREAM: begin
                n_row = r_row + PCM_CNT_W'(1);
                n_cnt = '0;
            end
            S_DRAIN: begin
                n_cnt = r_cnt + PCM_CNT_W'(1);
                n_row = '0;
                if (r_cnt == DRAIN_LEN - PCM_CNT_W'(1)) begin
                    case (r_op)
                        OP_COPY: begin
                            n_op = OP_CLOS;
                            n_k  = '0;
                        end
                        OP_CLOS, OP_INF: begin
                            if (last_k) begin
                                n_op = (r_op == OP_CLOS) ? OP_INF : OP_INIT;
                                n_k  = '0;
                            end else begin
                                n_k = r_k + PCM_IDX_W'(1);
                            end
                        end
                        OP_INIT: begin
                            n_op = OP_ACC;
                            n_k  = '0;
                        end
                        OP_ACC:  n_k = r_k + PCM_IDX_W'(1);
                        default: ;
                    endcase
                end
            end
            S_READ:  n_col = r_col + PCM_IDX_W'(1);
            default: ;
        endcase
    end

    // Outputs to the cells and the broadcast select
    always_comb begin
        o_ctl          = '0;
        o_ctl.op       = r_op;
        o_ctl.n        = r_nc;
        o_ctl.kk       = r_kk;
        o_ctl.bload    = (r_state == S_LATCH);
        o_ctl.edge_we  = accept && (cmd == CMD_ADD) && edge_ok;
        o_ctl.edge_row = PCM_IDX_W'(i_src_node);
        o_ctl.edge_col = PCM_IDX_W'(i_dst_node);
        bsel           = r_k;
        unique case (r_state)
            S_LOAD:   o_ctl.addr_b = r_k;
            S_STREAM: o_ctl.addr_b = r_row[PCM_IDX_W-1:0];
            S_READ: begin
                o_ctl.addr_b = r_rrow;
                bsel         = r_col;
            end
            default:  o_ctl.addr_b = r_k;
        endcase
    end

    // Registers; reset starts a clearing pass over all rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_op    <= OP_CLEAR;
            r_nc    <= PCM_CNT_W'(1);
            r_k     <= '0;
            r_row   <= '0;
            r_inj_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_nc    <= n_nc;
            r_k     <= n_k;
            r_row   <= n_row;
            r_inj_v <= (r_state == S_STREAM);
            r_ov    <= (r_state == S_READ);
        end
        r_cnt     <= n_cnt;
        r_rrow    <= n_rrow;
        r_col     <= n_col;
        r_msel    <= bsel;
        r_inj_row <= r_row[PCM_IDX_W-1:0];
        r_ocol    <= r_col[4:0];
        r_olast   <= (PCM_CNT_W'(r_col) == r_nc - PCM_CNT_W'(1));
        if (r_state == S_LATCH) r_kk <= i_sel_dat.r;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_inj_vld    = r_inj_v;
    assign o_inj_row    = r_inj_row;
    assign o_msel       = r_msel;
    assign o_valid      = r_ov;
    assign o_column     = r_ocol;
    assign o_last_entry = r_olast;

endmodule

// File: hw/rtl/path_count_matrix_unit.sv
// path_count_matrix_unit: top level, a chain of column cells driven by one sequencer.
// Depends on pcm_pkg, pcm_cell, pcm_ctrl.
//
// channel  | direction | handshake            | payload
// command  | in        | start / busy         | i_command, i_src_node, i_dst_node
// result   | out       | o_valid strobe       | o_path_count, o_column, o_last_entry
//
// Clear, compute and add-edge items give no result; a read item whose source node is
// below n gives n results, one per cycle, from the read state through the output
// registers. Add edge is written on acceptance and leaves the unit idle. Each pass
// over the rows runs the load, latch, stream and drain states (tokens drain through
// the chain of cells): clear is one pass of MAX_NODES rows, compute is 1 + 3n + 1
// passes. Reset is synchronous, sets node count 1 and runs one clearing pass (busy
// high) that zeroes the edge and count stores. The receiver cannot stall results.
module path_count_matrix_unit #(
    parameter int MAX_NODES = pcm_pkg::PCM_MAX_NODES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [4:0]         i_src_node,
    input  logic [4:0]         i_dst_node,
    output logic               o_valid,
    output logic signed [31:0] o_path_count,
    output logic [4:0]         o_column,
    output logic               o_last_entry
);
    import pcm_pkg::*;

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    t_cell_ctl ctl;
    t_tok      tok0;
    t_tok      tok [MAX_NODES];
    t_bdat     bd  [MAX_NODES];
    t_bdat     sel_dat;
    logic      inj_vld;
    logic [PCM_IDX_W-1:0] inj_row, msel;

    pcm_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_command    (i_command),
        .i_src_node   (i_src_node),
        .i_dst_node   (i_dst_node),
        .i_sel_dat    (sel_dat),
        .busy         (busy),
        .o_ctl        (ctl),
        .o_inj_vld    (inj_vld),
        .o_inj_row    (inj_row),
        .o_msel       (msel),
        .o_valid      (o_valid),
        .o_column     (o_column),
        .o_last_entry (o_last_entry)
    );

    // Pivot column value selected from the broadcast read port
    assign sel_dat = bd[msel[NW-1:0]];

    always_comb begin
        tok0.vld = inj_vld;
        tok0.row = inj_row;
        tok0.a_r = sel_dat.r;
        tok0.a_c = sel_dat.c;
    end

    // Chain of column cells
    for (genvar j = 0; j < MAX_NODES; j++) begin : g_cell
        pcm_cell #(.MAX_NODES(MAX_NODES), .J(j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tok   ((j == 0) ? tok0 : tok[(j == 0) ? 0 : j - 1]),
            .o_tok   (tok[j]),
            .o_bdat  (bd[j])
        );
    end

    assign o_path_count = signed'(sel_dat.c);

endmodule

// File: hw/rtl/pcm_checker.sv
// pcm_checker: port-level assertions for path_count_matrix_unit, bound to the top.
// Depends on pcm_pkg.
module pcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_command,
    input logic        o_valid,
    input logic [4:0]  o_column,
    input logic        o_last_entry
);
    import pcm_pkg::*;

    // A row streams while the unit stays busy
    a_busy_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_entry |-> busy) else $error("row result while idle");

    // Columns of a row follow in order with no gap
    a_col_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_entry |=> o_valid && (o_column == $past(o_column) + 5'd1))
        else $error("row columns out of order");

    // The last entry is not directly followed by another result
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_entry |=> !o_valid) else $error("result after last entry");

    // A compute item keeps the unit busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_command == CMD_COMPUTE) |=> busy && !o_valid)
        else $error("compute did not start");

endmodule

bind path_count_matrix_unit pcm_checker u_pcm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_command    (i_command),
    .o_valid      (o_valid),
    .o_column     (o_column),
    .o_last_entry (o_last_entry)
);
